@@ sv/redistribution_kernel_weight_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the redistribution kernel weight block
// Shorthand for clocked implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef REDISTRIBUTION_KERNEL_WEIGHT_MACROS_SVH
`define REDISTRIBUTION_KERNEL_WEIGHT_MACROS_SVH

// same-cycle implication
`define RKW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RKW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/rkw_pkg.sv @@
// ----------------------------------------------------------------------------
// rkw_pkg
// Shared types and codes for the redistribution kernel weight pipeline.
// ----------------------------------------------------------------------------
package rkw_pkg;

  // kernel select codes
  localparam logic [2:0] KSEL_BOX  = 3'd0;
  localparam logic [2:0] KSEL_LIN  = 3'd1;
  localparam logic [2:0] KSEL_QUAD = 3'd2;
  localparam logic [2:0] KSEL_CUB  = 3'd3;
  localparam logic [2:0] KSEL_M4P  = 3'd4;

  // rounding / scaling mode of the final magnitude
  localparam logic [1:0] SFT_12   = 2'd0;  // round, shift by 12
  localparam logic [1:0] SFT_13   = 2'd1;  // round, shift by 13
  localparam logic [1:0] SFT_26   = 2'd2;  // round, shift by 26
  localparam logic [1:0] SFT_DIV6 = 2'd3;  // round, divide by 6 * 2^25

  // reciprocal of 6 in Q16, exact for any dividend below 2^15
  localparam logic [13:0] RECIP6_Q16 = 14'd10923;

  // decoded operation for one item
  typedef struct packed {
    logic        dir;   // weight known directly, no arithmetic
    logic [15:0] dval;  // direct weight
    logic [13:0] fa;    // first product operands
    logic [13:0] fb;
    logic [15:0] fc;    // second product operand
    logic [14:0] bv;    // base = bv * 2^26, used when sub is set
    logic        sub;   // magnitude = base - product
    logic        neg;   // weight is minus the magnitude
    logic [1:0]  sft;   // rounding mode
    logic [2:0]  sup;   // support radius in half units
  } op_t;

endpackage

@@ sv/redistribution_kernel_weight.sv @@
// ----------------------------------------------------------------------------
// redistribution_kernel_weight
// Interpolation kernel weight (box, linear, quadratic, cubic, M4-prime).
// ----------------------------------------------------------------------------
// Takes one distance per clock and returns one weight per clock while the
// output is not stalled. Each distance passes the stages decode, first
// product, second product, round and shift, divide by six, and output, in
// that order. Every stage has its own valid bit and holds while the stage
// after it is full and stalled, so bubbles close up and the input keeps
// being taken while a finished result waits at the output, until no stage
// is left empty. The kernel select register is written through the cfg
// channel, which is always ready; write it only with the pipeline empty.
module redistribution_kernel_weight
  import rkw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config: [2:0] kernel_select, [7:3] unused
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [7:0]  cfg_tdata,
  // input: [15:0] distance
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // output: [15:0] weight, [18:16] support_half_units, [23:19] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata
);

  logic [2:0]  ksel_r;
  op_t         op_nxt;
  op_t         op1_r, op2_r, op3_r, op4_r, op5_r;
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic        en1, en2, en3, en4, en5, en6;
  logic [27:0] p1_nxt, p1_r;
  logic [43:0] p2_nxt, p2_r;
  logic [43:0] half;
  logic [43:0] x;
  logic [14:0] y_nxt, y_r;
  logic [28:0] qprod;
  logic [14:0] q_nxt, q_r;
  logic [15:0] w_nxt;
  logic [23:0] out_nxt, out_r;

  // configuration register
  assign cfg_tready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ksel_r <= KSEL_M4P;
    end else if (cfg_tvalid) begin
      ksel_r <= cfg_tdata[2:0];
    end
  end

  // per-stage advance: a stage loads when empty or when its content moves on
  assign en6 = !v6_r || out_tready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  // stage 1: branch decode
  rkw_decode u_decode (
    .distance (in_tdata[15:0]),
    .ksel     (ksel_r),
    .op       (op_nxt)
  );

  // stage 2: first product
  assign p1_nxt = op1_r.fa * op1_r.fb;

  // stage 3: second product
  assign p2_nxt = p1_r * op2_r.fc;

  // stage 4: rounding offset, optional subtract from base, then shift
  always_comb begin
    case (op3_r.sft)
      SFT_12:   half = 44'd1 << 11;
      SFT_13:   half = 44'd1 << 12;
      SFT_26:   half = 44'd1 << 25;
      SFT_DIV6: half = 44'd3 << 25;
      default:  half = '0;
    endcase
  end

  // base has clear low bits, so the offset is simply or-ed in
  assign x = op3_r.sub ? (({3'b0, op3_r.bv, 26'b0} | half) - p2_r) : (p2_r + half);

  always_comb begin
    case (op3_r.sft)
      SFT_12:   y_nxt = x[26:12];
      SFT_13:   y_nxt = x[27:13];
      SFT_26:   y_nxt = x[40:26];
      SFT_DIV6: y_nxt = x[39:25];
      default:  y_nxt = '0;
    endcase
  end

  // stage 5: divide by six through the reciprocal
  assign qprod = y_r * RECIP6_Q16;
  assign q_nxt = (op4_r.sft == SFT_DIV6) ? {2'b0, qprod[28:16]} : y_r;

  // stage 6: sign, direct values, pack
  always_comb begin
    if (op5_r.dir) begin
      w_nxt = op5_r.dval;
    end else if (op5_r.neg) begin
      w_nxt = 16'd0 - {1'b0, q_r};
    end else begin
      w_nxt = {1'b0, q_r};
    end
  end

  assign out_nxt = {5'b0, op5_r.sup, w_nxt};

  // payload registers
  always_ff @(posedge clk) begin
    if (en1) op1_r <= op_nxt;
    if (en2) begin
      op2_r <= op1_r;
      p1_r  <= p1_nxt;
    end
    if (en3) begin
      op3_r <= op2_r;
      p2_r  <= p2_nxt;
    end
    if (en4) begin
      op4_r <= op3_r;
      y_r   <= y_nxt;
    end
    if (en5) begin
      op5_r <= op4_r;
      q_r   <= q_nxt;
    end
    if (en6) out_r <= out_nxt;
  end

  assign out_tvalid = v6_r;
  assign out_tdata  = out_r;

endmodule

@@ sv/rkw_decode.sv @@
// ----------------------------------------------------------------------------
// rkw_decode
// Picks the kernel branch for a distance and sets up the polynomial factors.
// ----------------------------------------------------------------------------
module rkw_decode
  import rkw_pkg::*;
(
  input  logic [15:0] distance,
  input  logic [2:0]  ksel,
  output op_t         op
);

  logic [16:0] d17;
  logic [16:0] m8k;    // 8192 - d
  logic [16:0] d8k;    // d - 8192
  logic [16:0] m16k;   // 16384 - d
  logic [16:0] m24k;   // 24576 - d
  logic [16:0] m40k;   // 40960 - 3d
  logic        lt4k, lt8k, le8k, lt12k, lt16k;

  assign d17  = {1'b0, distance};
  assign m8k  = 17'd8192 - d17;
  assign d8k  = d17 - 17'd8192;
  assign m16k = 17'd16384 - d17;
  assign m24k = 17'd24576 - d17;
  assign m40k = 17'd40960 - ((d17 << 1) + d17);

  assign lt4k  = (distance < 16'd4096);
  assign lt8k  = (distance < 16'd8192);
  assign le8k  = (distance <= 16'd8192);
  assign lt12k = (distance < 16'd12288);
  assign lt16k = (distance < 16'd16384);

  // branch selection per kernel
  always_comb begin
    op      = '0;
    op.fc   = 16'd1;
    op.sft  = SFT_26;
    case (ksel)
      KSEL_BOX: begin
        op.sup  = 3'd1;
        op.dir  = 1'b1;
        op.dval = lt4k ? 16'd16384 : 16'd0;
      end
      KSEL_LIN: begin
        op.sup  = 3'd2;
        op.dir  = 1'b1;
        op.dval = le8k ? {m8k[14:0], 1'b0} : 16'd0;
      end
      KSEL_QUAD: begin
        op.sup = 3'd3;
        if (lt4k) begin
          // 1 - u^2
          op.fa  = distance[13:0];
          op.fb  = distance[13:0];
          op.sub = 1'b1;
          op.bv  = 15'd1;
          op.sft = SFT_12;
        end else if (lt12k) begin
          // (1-u)(2-u)/2, negative past u = 1
          op.fa  = le8k ? m8k[13:0] : d8k[13:0];
          op.fb  = m16k[13:0];
          op.neg = !le8k;
          op.sft = SFT_13;
        end else begin
          op.dir = 1'b1;
        end
      end
      KSEL_CUB: begin
        op.sup = 3'd4;
        if (lt8k) begin
          // (1-u^2)(2-u)/2
          op.fa  = distance[13:0];
          op.fb  = distance[13:0];
          op.fc  = m16k[15:0];
          op.sub = 1'b1;
          op.bv  = m16k[14:0];
        end else if (lt16k) begin
          // (1-u)(2-u)(3-u)/6, never positive here
          op.fa  = d8k[13:0];
          op.fb  = m16k[13:0];
          op.fc  = m24k[15:0];
          op.neg = 1'b1;
          op.sft = SFT_DIV6;
        end else begin
          op.dir = 1'b1;
        end
      end
      default: begin
        // M4-prime; unused codes land here too
        op.sup = 3'd4;
        if (lt8k) begin
          // 1 - u^2 (5/2 - 3/2 u)
          op.fa  = distance[13:0];
          op.fb  = distance[13:0];
          op.fc  = m40k[15:0];
          op.sub = 1'b1;
          op.bv  = 15'd16384;
        end else if (lt16k) begin
          // (1-u)(2-u)^2/2
          op.fa  = d8k[13:0];
          op.fb  = m16k[13:0];
          op.fc  = m16k[15:0];
          op.neg = 1'b1;
        end else begin
          op.dir = 1'b1;
        end
      end
    endcase
  end

endmodule

@@ sv/rkw_checker.sv @@
// ----------------------------------------------------------------------------
// rkw_checker
// Port-level checks on the result stream of the kernel weight block.
// ----------------------------------------------------------------------------
`include "redistribution_kernel_weight_macros.svh"

module rkw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  logic signed [15:0] w;
  logic [2:0]         sup;

  assign w   = $signed(out_tdata[15:0]);
  assign sup = out_tdata[18:16];

  // a held result stays put until taken
  `RKW_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // support radius is one of the kernel radii, padding is clear
  `RKW_ASSERT_IMP(a_sup, out_tvalid, (sup == 3'd1 || sup == 3'd2 || sup == 3'd3 || sup == 3'd4) && out_tdata[23:19] == 5'd0, "bad support or padding")

  // every kernel stays between the deepest negative lobe (quadratic) and one
  `RKW_ASSERT_IMP(a_range, out_tvalid, w >= -16'sd2048 && w <= 16'sd16384, "weight out of kernel range")

  // box kernel only gives zero or one
  `RKW_ASSERT_IMP(a_box, out_tvalid && sup == 3'd1, w == 16'sd0 || w == 16'sd16384, "box weight not 0 or 1")

  // linear kernel has no negative lobe
  `RKW_ASSERT_IMP(a_lin, out_tvalid && sup == 3'd2, w >= 16'sd0, "negative linear weight")

endmodule

bind redistribution_kernel_weight rkw_checker u_rkw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ verif/tb_redistribution_kernel_weight.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_redistribution_kernel_weight
// Self-checking bench for the interpolation kernel weight pipeline.
// ----------------------------------------------------------------------------
// Streams distances into the block under every kernel select code and checks
// each weight and support radius against a cycle-free integer predictor.
// A directed part hits each kernel's piece boundaries, the reset default and
// the unused codes; random phases follow with input gaps and output stalls
// swapped between them and finally switched off.
module tb_redistribution_kernel_weight
  import rkw_pkg::*;
();

  // unused select codes, expected to behave as M4-prime
  localparam logic [2:0] KSEL_RSV5 = 3'd5;
  localparam logic [2:0] KSEL_RSV6 = 3'd6;
  localparam logic [2:0] KSEL_RSV7 = 3'd7;

  // unsigned Q3.13 landmarks
  localparam longint ONE_Q13    = 8192;
  localparam longint HALF_Q13   = 4096;
  localparam longint ONEHALF_Q13 = 12288;
  localparam longint TWO_Q13    = 16384;

  localparam int     CHUNK_ITEMS = 30;
  localparam int     DRAIN_CYCLES = 10;
  localparam longint RUN_LIMIT_NS = 5_000_000;

  typedef struct {
    logic signed [15:0] weight;
    logic [2:0]         sup;
  } kernel_weight_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_tvalid = 1'b0;
  logic        cfg_tready;
  logic [7:0]  cfg_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] distance
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [15:0] weight, [18:16] support_half_units

  kernel_weight_t pending_weights[$];
  logic [2:0]     model_ksel = KSEL_M4P;
  int             in_idle_pct = 0;
  int             out_stall_pct = 0;
  int             n_fail = 0;

  redistribution_kernel_weight u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // num/den to nearest, ties away from zero
  function automatic longint round_nearest(input longint num, input longint den);
    longint half;
    half = den / 2;
    if (num >= 0) begin
      return (num + half) / den;
    end
    return -((-num + half) / den);
  endfunction

  function automatic kernel_weight_t predict_weight(input logic [2:0] ksel,
                                                    input logic [15:0] dist_val);
    longint d;
    longint w;
    longint t;
    kernel_weight_t r;
    d = longint'(dist_val);
    w = 0;
    case (ksel)
      KSEL_BOX: begin
        w = (d < HALF_Q13) ? 16384 : 0;
        r.sup = 3'd1;
      end
      KSEL_LIN: begin
        w = (d <= ONE_Q13) ? (ONE_Q13 - d) * 2 : 0;
        r.sup = 3'd2;
      end
      KSEL_QUAD: begin
        if (d < HALF_Q13) begin
          w = round_nearest((longint'(1) << 26) - d * d, longint'(1) << 12);
        end else if (d < ONEHALF_Q13) begin
          w = round_nearest((ONE_Q13 - d) * (TWO_Q13 - d), longint'(1) << 13);
        end
        r.sup = 3'd3;
      end
      KSEL_CUB: begin
        if (d < ONE_Q13) begin
          w = round_nearest(((longint'(1) << 26) - d * d) * (TWO_Q13 - d),
                            longint'(1) << 26);
        end else if (d < TWO_Q13) begin
          w = round_nearest((ONE_Q13 - d) * (TWO_Q13 - d) * (3 * ONE_Q13 - d),
                            longint'(6) << 25);
        end
        r.sup = 3'd4;
      end
      default: begin
        // M4-prime, also taken by the unused codes
        if (d < ONE_Q13) begin
          w = round_nearest((longint'(1) << 40) - 5 * d * d * (longint'(1) << 13)
                            + 3 * d * d * d, longint'(1) << 26);
        end else if (d < TWO_Q13) begin
          t = TWO_Q13 - d;
          w = round_nearest((ONE_Q13 - d) * t * t, longint'(1) << 26);
        end
        r.sup = 3'd4;
      end
    endcase
    if (w > 32767) w = 32767;
    if (w < -32768) w = -32768;
    r.weight = w[15:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls and checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    kernel_weight_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_weights.size() == 0) begin
        $error("unexpected result item, out_tdata=%h", out_tdata);
        n_fail++;
      end else begin
        exp_w = pending_weights.pop_front();
        if (out_tdata[15:0] !== exp_w.weight) begin
          $error("weight: expected %0d, actual %0d", exp_w.weight,
                 $signed(out_tdata[15:0]));
          n_fail++;
        end
        if (out_tdata[18:16] !== exp_w.sup) begin
          $error("support_half_units: expected %0d, actual %0d", exp_w.sup,
                 out_tdata[18:16]);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // returns in the step of acceptance with in_tvalid still high
  task automatic send_distance(input logic [15:0] dist_val);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < in_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dist_val;
    do @(posedge clk); while (!in_tready);
    pending_weights.push_back(predict_weight(model_ksel, dist_val));
  endtask

  // drop valid, let every result come out, then let the pipe settle
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write on an idle pipeline; upper data bits are don't-care
  task automatic write_kernel_select(input logic [2:0] code);
    drain_pipeline();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {5'($urandom), code};
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    model_ksel = code;
  endtask

  // mostly inside the support, some near piece boundaries, some anywhere
  function automatic logic [15:0] random_distance();
    int pick;
    longint bp;
    pick = $urandom_range(0, 9);
    if (pick <= 5) begin
      return 16'($urandom_range(0, 17000));
    end
    if (pick <= 7) begin
      case ($urandom_range(0, 3))
        0:       bp = HALF_Q13;
        1:       bp = ONE_Q13;
        2:       bp = ONEHALF_Q13;
        default: bp = TWO_Q13;
      endcase
      return 16'(bp + $urandom_range(0, 6) - 3);
    end
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // no register write yet: the reset default must be M4-prime
  task automatic test_reset_default();
    send_distance(16'd0);
    send_distance(16'd8191);
    send_distance(16'd8192);
    send_distance(16'd16383);
    send_distance(16'd16384);
    send_distance(16'hFFFF);
  endtask

  // boundaries of each piece of the box, linear, quadratic and cubic kernels
  task automatic test_kernel_boundaries();
    write_kernel_select(KSEL_BOX);
    send_distance(16'd0);
    send_distance(16'd4095);
    send_distance(16'd4096);
    send_distance(16'hFFFF);
    write_kernel_select(KSEL_LIN);
    send_distance(16'd0);
    send_distance(16'd8192);
    send_distance(16'd8193);
    write_kernel_select(KSEL_QUAD);
    send_distance(16'd4095);
    send_distance(16'd4096);
    send_distance(16'd12287);
    send_distance(16'd12288);
    write_kernel_select(KSEL_CUB);
    send_distance(16'd8191);
    send_distance(16'd8192);
    send_distance(16'd16383);
    send_distance(16'd16384);
  endtask

  // codes 5..7 fall back to M4-prime
  task automatic test_unused_codes();
    write_kernel_select(KSEL_RSV5);
    send_distance(16'd4096);
    write_kernel_select(KSEL_RSV6);
    send_distance(16'd12000);
    write_kernel_select(KSEL_RSV7);
    send_distance(16'd100);
  endtask

  // random distances under a rotating kernel select
  task automatic test_random_phase(input int phase, input int idle_pct,
                                   input int stall_pct);
    logic [2:0] ksel_order[8];
    ksel_order = '{KSEL_BOX, KSEL_RSV7, KSEL_LIN, KSEL_M4P,
                   KSEL_QUAD, KSEL_RSV5, KSEL_CUB, KSEL_RSV6};
    in_idle_pct   = idle_pct;
    out_stall_pct = stall_pct;
    for (int c = 0; c < 6; c++) begin
      write_kernel_select(ksel_order[(phase * 6 + c) % 8]);
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        send_distance(random_distance());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct   = 34;
    out_stall_pct = 62;
    test_reset_default();
    test_kernel_boundaries();
    test_unused_codes();

    test_random_phase(0, 34, 62);
    test_random_phase(1, 62, 34);
    test_random_phase(2, 0, 0);

    drain_pipeline();
    if (n_fail == 0) begin
      $display("tb_redistribution_kernel_weight passed");
    end else begin
      $display("tb_redistribution_kernel_weight failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_redistribution_kernel_weight failed");
    $finish;
  end

endmodule
